[hdl/spirc_pkg.sv]
package spirc_pkg;

    // request kinds carried in the input tuser
    localparam logic [1:0] REQ_REG_READ  = 2'd0;
    localparam logic [1:0] REQ_REG_WRITE = 2'd1;
    localparam logic [1:0] REQ_PAYLOAD   = 2'd2;

    // command bytes
    localparam logic [7:0] CMD_WRITE   = 8'h20;
    localparam logic [7:0] CMD_PAYLOAD = 8'h61;

    // half-tick counts at which a transaction finishes
    localparam logic [6:0] HALF_TICKS_REG     = 7'd32;
    localparam logic [6:0] HALF_TICKS_PAYLOAD = 7'd80;

    // bit positions
    localparam logic [5:0] DRIVEN_BITS_CMD   = 6'd8;
    localparam logic [5:0] DRIVEN_BITS_WRITE = 6'd16;
    localparam logic [5:0] CAPTURE_FIRST_BIT = 6'd8;
    localparam logic [5:0] CAPTURE_END_BIT   = 6'd24;

    // one classified tick, front to back
    typedef struct packed {
        logic        start_req;
        logic [1:0]  kind;
        logic [15:0] word;
        logic        miso;
    } t_tick;

    // pin levels and status for one tick, back to output
    typedef struct packed {
        logic [15:0] read_data;
        logic        done;
        logic        busy;
        logic        mosi;
        logic        sck;
        logic        csn;
    } t_result;

endpackage

[hdl/spi_radio_command_master.sv]
// spi mode-0 command master for a radio transceiver. every input transaction is one
// half-bit tick of the serial clock and gives exactly one output transaction with the
// pin levels (csn, sck, mosi) and status for that tick. a tick flagged as a request
// (read, write or payload read) starts a serial transaction when the master is idle;
// requests seen while a transaction runs, including its finishing tick, are dropped,
// as is request kind 3. register transactions take 33 ticks, payload reads 81 ticks,
// the last one with done high and the 16 captured bits (first captured bit in bit 15).
// throughput is one tick per clock cycle while the output is not stalled: the shift
// sequencer in the back end advances in each cycle in which it pops a tick. a tick is
// queued when taken and registered at the output when popped. the input side keeps taking
// ticks while a result waits, until the queue between front end and sequencer is full.
module spi_radio_command_master #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // reg_addr[4:0], write_data[12:5], miso_in[13], zero
    input  logic [2:0]  s_axis_tuser,   // req_valid[0], req_type[2:1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // csn_out[0], sck_out[1], mosi_out[2], busy_res[3],
                                        // done_res[4], read_data[20:5], zero
);

    spirc_pkg::t_tick   w_tick_in;
    spirc_pkg::t_tick   w_tick_q;
    spirc_pkg::t_result w_result;
    logic               w_full;
    logic               w_q_valid;
    logic               w_pop;

    // front end: classify the tick into start request, kind and command word
    spirc_front u_front (
        .i_tdata (s_axis_tdata),
        .i_tuser (s_axis_tuser),
        .o_tick  (w_tick_in)
    );

    assign s_axis_tready = !w_full;

    // short queue decouples input acceptance from the sequencer
    spirc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_data  (w_tick_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_tick_q)
    );

    // back end: serial sequencer with registered output
    spirc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_tick   (w_tick_q),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {3'b000, w_result.read_data, w_result.done, w_result.busy,
                           w_result.mosi, w_result.sck, w_result.csn};

endmodule

[hdl/spirc_front.sv]
module spirc_front (
    input  logic [15:0]       i_tdata,
    input  logic [2:0]        i_tuser,
    output spirc_pkg::t_tick  o_tick
);

    logic [1:0] w_type;
    logic [4:0] w_addr;
    logic [7:0] w_data;

    assign w_type = i_tuser[2:1];
    assign w_addr = i_tdata[4:0];
    assign w_data = i_tdata[12:5];

    always_comb begin
        o_tick.kind      = w_type;
        o_tick.miso      = i_tdata[13];
        o_tick.start_req = i_tuser[0] && (w_type inside {spirc_pkg::REQ_REG_READ,
                                                         spirc_pkg::REQ_REG_WRITE,
                                                         spirc_pkg::REQ_PAYLOAD});
        case (w_type)
            spirc_pkg::REQ_REG_READ:  o_tick.word = {3'b000, w_addr, 8'h00};
            spirc_pkg::REQ_REG_WRITE: o_tick.word = {spirc_pkg::CMD_WRITE | {3'b000, w_addr},
                                                     w_data};
            default:                  o_tick.word = {spirc_pkg::CMD_PAYLOAD, 8'h00};
        endcase
    end

endmodule

[hdl/spirc_queue.sv]
module spirc_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  spirc_pkg::t_tick  i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output spirc_pkg::t_tick  o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    spirc_pkg::t_tick r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[hdl/spirc_back.sv]
module spirc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  spirc_pkg::t_tick    i_tick,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output spirc_pkg::t_result  o_result
);

    logic        r_active, n_active;
    logic [1:0]  r_kind, n_kind;
    logic [6:0]  r_cnt, n_cnt;
    logic [15:0] r_out_shift, n_out_shift;
    logic [15:0] r_in_shift, n_in_shift;
    logic        r_mosi, n_mosi;
    logic        r_out_valid;
    spirc_pkg::t_result r_out, n_out;

    logic        w_start;
    logic [6:0]  w_cnt;
    logic [6:0]  w_limit;
    logic [5:0]  w_driven;
    logic [5:0]  w_bit;
    logic        w_capture;

    assign o_pop    = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        w_start     = !r_active && i_tick.start_req;
        n_active    = r_active || w_start;
        n_kind      = w_start ? i_tick.kind : r_kind;
        w_cnt       = w_start ? 7'd0 : r_cnt;
        n_out_shift = w_start ? i_tick.word : r_out_shift;
        n_in_shift  = w_start ? 16'd0 : r_in_shift;
        n_mosi      = r_mosi;
        n_cnt       = w_cnt;

        w_limit   = (n_kind == spirc_pkg::REQ_PAYLOAD) ? spirc_pkg::HALF_TICKS_PAYLOAD
                                                       : spirc_pkg::HALF_TICKS_REG;
        w_driven  = (n_kind == spirc_pkg::REQ_REG_WRITE) ? spirc_pkg::DRIVEN_BITS_WRITE
                                                         : spirc_pkg::DRIVEN_BITS_CMD;
        w_bit     = w_cnt[6:1];
        w_capture = (n_kind != spirc_pkg::REQ_PAYLOAD) ||
                    ((w_bit >= spirc_pkg::CAPTURE_FIRST_BIT) &&
                     (w_bit <  spirc_pkg::CAPTURE_END_BIT));

        n_out.csn       = 1'b1;
        n_out.sck       = 1'b0;
        n_out.busy      = 1'b0;
        n_out.done      = 1'b0;
        n_out.read_data = 16'd0;

        if (n_active) begin
            if (w_cnt >= w_limit) begin
                // finishing tick: release chip select, report capture
                n_out.done      = 1'b1;
                n_out.read_data = n_in_shift;
                n_active        = 1'b0;
                n_cnt           = 7'd0;
            end else begin
                n_out.csn  = 1'b0;
                n_out.busy = 1'b1;
                if (!w_cnt[0]) begin
                    if (w_bit < w_driven) begin
                        n_mosi      = n_out_shift[15];
                        n_out_shift = {n_out_shift[14:0], 1'b0};
                    end
                end else begin
                    n_out.sck = 1'b1;
                    if (w_capture) begin
                        n_in_shift = {n_in_shift[14:0], i_tick.miso};
                    end
                end
                n_cnt = w_cnt + 7'd1;
            end
        end
        n_out.mosi = n_mosi;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_kind      <= 2'd0;
            r_cnt       <= 7'd0;
            r_out_shift <= 16'd0;
            r_in_shift  <= 16'd0;
            r_mosi      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_active    <= n_active;
                r_kind      <= n_kind;
                r_cnt       <= n_cnt;
                r_out_shift <= n_out_shift;
                r_in_shift  <= n_in_shift;
                r_mosi      <= n_mosi;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

[hdl/spirc_checker.sv]
module spirc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // chip select is low exactly while busy
    a_csn_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] != m_axis_tdata[3]))
        else $error("csn and busy disagree");

    // finishing tick releases chip select and is not busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> (m_axis_tdata[0] && !m_axis_tdata[3]))
        else $error("done while selected");

    // read data only shows on the finishing tick
    a_rdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[4]) |-> (m_axis_tdata[20:5] == 16'd0))
        else $error("read data outside done");

    // serial clock only toggles inside a transaction
    a_sck_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[3])
        else $error("sck high while idle");

    // stalled output holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output changed under stall");

endmodule

bind spi_radio_command_master spirc_checker u_spirc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
